FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro takes a label, a clock, an active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/frs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg: shared definitions for the fall recovery sequencer
// Phase, action and register index codes, field widths and reset defaults.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int unsigned MaxAttemptsDef = 3;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned DriveW   = 15;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned MsW      = 16;
    localparam int unsigned AttW     = 4;
    localparam int unsigned PhaseW   = 3;

    typedef enum logic [PhaseW-1:0] {
        PhSettle    = 3'd0,
        PhWindup    = 3'd1,
        PhKick      = 3'd2,
        PhCoast     = 3'd3,
        PhDone      = 3'd4,
        PhExhausted = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ActTick  = 2'd0,
        ActBegin = 2'd1,
        ActRetry = 2'd2,
        ActAbort = 2'd3
    } action_t;

    typedef enum logic [CfgIdxW-1:0] {
        RegSettledRateLimit = 3'd0,
        RegSettleHoldTime   = 3'd1,
        RegWindupDrive      = 3'd2,
        RegWindupTime       = 3'd3,
        RegKickDrive        = 3'd4,
        RegKickTime         = 3'd5,
        RegCoastTime        = 3'd6,
        RegRetryDelay       = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam logic [DriveW-1:0] SettledRateLimitRst = 15'd80;
    localparam logic [MsW-1:0]    SettleHoldTimeRst   = 16'd300;
    localparam logic [DriveW-1:0] WindupDriveRst      = 15'd13107;
    localparam logic [MsW-1:0]    WindupTimeRst       = 16'd150;
    localparam logic [DriveW-1:0] KickDriveRst        = 15'd32767;
    localparam logic [MsW-1:0]    KickTimeRst         = 16'd200;
    localparam logic [MsW-1:0]    CoastTimeRst        = 16'd400;
    localparam logic [MsW-1:0]    RetryDelayRst       = 16'd500;

    localparam logic [AttW-1:0] AttMax = 4'd15;

endpackage

FILE: hw/rtl/fall_recovery_sequencer.sv
`timescale 1ns / 1ps
// Two register stages: the input register, then the result register; a word moves on
// from the input register whenever the result register is free. Throughput: one word per
// cycle while the result register is not stalled; the phase update is a single registered pass.
// The input register stalls only while the result register is full and stalled.
// Reset (rst_n low, asynchronous) clears both stages, returns the phase to done
// with no attempts counted, and loads every configuration register default.
// ----------------------------------------------------------------------------
// fall_recovery_sequencer: self-righting phase sequencer
// Steps settle, windup, kick, coast and done on tick words; begin, retry and
// abort words re-arm or end the maneuver. One result word per input word.
// ----------------------------------------------------------------------------
module fall_recovery_sequencer #(
    parameter int unsigned MAX_ATTEMPTS = frs_pkg::MaxAttemptsDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write_en,
    input  logic [frs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [frs_pkg::CfgDataW-1:0] cfg_data,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic                         fall_fwd,
    input  logic signed [15:0]           pitch_rate,
    input  logic [frs_pkg::TimeW-1:0]    now_time,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         drive_valid,
    output logic                         motor_mode,
    output logic signed [15:0]           motor_duty,
    output logic                         clear_odometry,
    output logic [frs_pkg::PhaseW-1:0]   phase_now,
    output logic [frs_pkg::AttW-1:0]     attempt_count
);
    import frs_pkg::*;

    localparam logic [AttW-1:0] MaxAtt = AttW'(MAX_ATTEMPTS);

    // configuration registers
    logic [DriveW-1:0] rate_limit_reg;
    logic [MsW-1:0]    hold_time_reg;
    logic [DriveW-1:0] windup_drive_reg;
    logic [MsW-1:0]    windup_time_reg;
    logic [DriveW-1:0] kick_drive_reg;
    logic [MsW-1:0]    kick_time_reg;
    logic [MsW-1:0]    coast_time_reg;
    logic [MsW-1:0]    retry_delay_reg;

    // input stage
    logic              s1_valid_reg;
    action_t           s1_action_reg;
    logic              s1_fwd_reg;
    logic [15:0]       s1_rate_reg;
    logic [TimeW-1:0]  s1_now_reg;

    // sequencer state
    phase_t            phase_reg, phase_next;
    logic [AttW-1:0]   attempts_reg, attempts_next;
    logic              fwd_reg, fwd_next;
    logic [TimeW-1:0]  phase_start_reg, phase_start_next;
    logic [TimeW-1:0]  settled_start_reg, settled_start_next;

    // result stage
    logic              out_valid_reg;
    logic              drive_valid_reg, drive_valid_next;
    logic              mode_reg, mode_next;
    logic [15:0]       duty_reg, duty_next;
    logic              clr_reg, clr_next;

    logic              out_free;
    logic              s1_move;
    logic [15:0]       rate_mag;
    logic [TimeW-1:0]  elapsed_phase;
    logic [TimeW-1:0]  elapsed_hold;
    logic [AttW-1:0]   attempts_inc;

    // Handshake: the result register frees when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg   <= SettledRateLimitRst;
            hold_time_reg    <= SettleHoldTimeRst;
            windup_drive_reg <= WindupDriveRst;
            windup_time_reg  <= WindupTimeRst;
            kick_drive_reg   <= KickDriveRst;
            kick_time_reg    <= KickTimeRst;
            coast_time_reg   <= CoastTimeRst;
            retry_delay_reg  <= RetryDelayRst;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                RegSettledRateLimit: rate_limit_reg   <= cfg_data[DriveW-1:0];
                RegSettleHoldTime:   hold_time_reg    <= cfg_data;
                RegWindupDrive:      windup_drive_reg <= cfg_data[DriveW-1:0];
                RegWindupTime:       windup_time_reg  <= cfg_data;
                RegKickDrive:        kick_drive_reg   <= cfg_data[DriveW-1:0];
                RegKickTime:         kick_time_reg    <= cfg_data;
                RegCoastTime:        coast_time_reg   <= cfg_data;
                RegRetryDelay:       retry_delay_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: capture a word whenever the stage is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action_t'(action);
            s1_fwd_reg    <= fall_fwd;
            s1_rate_reg   <= pitch_rate;
            s1_now_reg    <= now_time;
        end
    end

    // Rate magnitude; the most negative rate reads as 32768 unsigned
    assign rate_mag      = s1_rate_reg[15] ? 16'(-s1_rate_reg) : s1_rate_reg;
    assign elapsed_phase = s1_now_reg - phase_start_reg;
    assign elapsed_hold  = s1_now_reg - settled_start_reg;
    assign attempts_inc  = (attempts_reg == AttMax) ? attempts_reg : attempts_reg + 4'd1;

    // Phase update and result for the word in the input register
    always_comb
    begin
        phase_next         = phase_reg;
        attempts_next      = attempts_reg;
        fwd_next           = fwd_reg;
        phase_start_next   = phase_start_reg;
        settled_start_next = settled_start_reg;
        drive_valid_next   = 1'b0;
        mode_next          = 1'b0;
        duty_next          = 16'd0;
        clr_next           = 1'b0;

        unique case (s1_action_reg)
            ActBegin:
            begin
                fwd_next           = s1_fwd_reg;
                phase_next         = PhSettle;
                phase_start_next   = '0;
                settled_start_next = '0;
            end
            ActRetry:
            begin
                attempts_next = attempts_inc;
                if (attempts_inc >= MaxAtt)
                begin
                    phase_next = PhExhausted;
                end
                else
                begin
                    phase_next         = PhSettle;
                    settled_start_next = '0;
                    phase_start_next   = s1_now_reg + {{(TimeW-MsW){1'b0}}, retry_delay_reg};
                end
            end
            ActAbort:
            begin
                phase_next         = PhDone;
                attempts_next      = '0;
                settled_start_next = '0;
            end
            default:
            begin
                drive_valid_next = 1'b1;
                unique case (phase_reg)
                    PhSettle:
                    begin
                        if (s1_now_reg < phase_start_reg)
                        begin
                            settled_start_next = '0;
                        end
                        else if (rate_mag > {1'b0, rate_limit_reg})
                        begin
                            settled_start_next = '0;
                        end
                        else if (settled_start_reg == '0)
                        begin
                            settled_start_next = s1_now_reg;
                        end
                        else if (elapsed_hold >= {{(TimeW-MsW){1'b0}}, hold_time_reg})
                        begin
                            clr_next         = 1'b1;
                            phase_next       = PhWindup;
                            phase_start_next = s1_now_reg;
                        end
                    end
                    PhWindup:
                    begin
                        mode_next = 1'b1;
                        duty_next = fwd_reg ? {1'b0, windup_drive_reg}
                                            : 16'(-{1'b0, windup_drive_reg});
                        if (elapsed_phase >= {{(TimeW-MsW){1'b0}}, windup_time_reg})
                        begin
                            phase_next       = PhKick;
                            phase_start_next = s1_now_reg;
                        end
                    end
                    PhKick:
                    begin
                        mode_next = 1'b1;
                        duty_next = fwd_reg ? 16'(-{1'b0, kick_drive_reg})
                                            : {1'b0, kick_drive_reg};
                        if (elapsed_phase >= {{(TimeW-MsW){1'b0}}, kick_time_reg})
                        begin
                            phase_next       = PhCoast;
                            phase_start_next = s1_now_reg;
                        end
                    end
                    PhCoast:
                    begin
                        if (elapsed_phase >= {{(TimeW-MsW){1'b0}}, coast_time_reg})
                        begin
                            phase_next       = PhDone;
                            phase_start_next = s1_now_reg;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // Hold state; advance it as each word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PhDone;
            attempts_reg      <= '0;
            fwd_reg           <= 1'b0;
            phase_start_reg   <= '0;
            settled_start_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                phase_reg         <= phase_next;
                attempts_reg      <= attempts_next;
                fwd_reg           <= fwd_next;
                phase_start_reg   <= phase_start_next;
                settled_start_reg <= settled_start_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            drive_valid_reg <= drive_valid_next;
            mode_reg        <= mode_next;
            duty_reg        <= duty_next;
            clr_reg         <= clr_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_valid    = drive_valid_reg;
    assign motor_mode     = mode_reg;
    assign motor_duty     = duty_reg;
    assign clear_odometry = clr_reg;
    assign phase_now      = phase_reg;
    assign attempt_count  = attempts_reg;

endmodule

FILE: hw/rtl/frs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_checker: port-level checks for the fall recovery sequencer
// Watches the result channel for command and phase consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frs_checker #(
    parameter int unsigned MAX_ATTEMPTS = frs_pkg::MaxAttemptsDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         drive_valid,
    input  logic                         motor_mode,
    input  logic signed [15:0]           motor_duty,
    input  logic                         clear_odometry,
    input  logic [frs_pkg::PhaseW-1:0]   phase_now,
    input  logic [frs_pkg::AttW-1:0]     attempt_count
);
    import frs_pkg::*;

    localparam logic [AttW-1:0] MaxAtt = AttW'(MAX_ATTEMPTS);

    // Non-tick words carry no motor command
    `ASSERT_IMPLY(a_no_cmd_off_tick, clk, rst_n, out_valid && !drive_valid,
        !motor_mode && motor_duty == 16'sd0 && !clear_odometry)

    // Words with the motor mode off, coasting among them, carry zero duty
    `ASSERT_IMPLY(a_coast_zero_duty, clk, rst_n, out_valid && !motor_mode,
        motor_duty == 16'sd0)

    // Odometry clears only on the tick that enters windup
    `ASSERT_IMPLY(a_clear_enters_windup, clk, rst_n, out_valid && clear_odometry,
        drive_valid && phase_now == PhWindup)

    // Exhausted is reached only once the attempt limit is counted
    `ASSERT_IMPLY(a_exhausted_count, clk, rst_n, out_valid && phase_now == PhExhausted,
        attempt_count >= MaxAtt)

    // A stalled result word holds
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(phase_now) && $stable(attempt_count))

endmodule

bind fall_recovery_sequencer frs_checker #(
    .MAX_ATTEMPTS(MAX_ATTEMPTS)
) u_frs_checker (.*);
